>>> rtl/mmc3v_pkg.sv
// Package for the MMC3 variant bank mapper.
// Holds item structs, function and register codes, and shared helper functions.
// No dependencies.
package mmc3v_pkg;

  localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
  localparam logic [1:0] FUNC_PPU_READ  = 2'd2;

  localparam logic [1:0] CFG_RAM_WRITE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_PRG_BANK_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_CHR_BANK_LIMIT   = 2'd2;

  localparam int CHR_SLOTS = 8;
  localparam int BANK_REG_AW = $clog2(CHR_SLOTS);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  data_byte;
  } mmc3v_in_t;

  typedef struct packed {
    logic [7:0]  bank_number;
    logic [20:0] rom_offset;
    logic        forwarded;
  } mmc3v_out_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        forwarded;
    logic [7:0]  prg_bank;
    logic [2:0]  chr_slot;
    logic [12:0] low_address;
  } mmc3v_stage_t;

  function automatic logic [7:0] bank_reg_reset(input logic [BANK_REG_AW-1:0] idx);
    logic [7:0] value;
    case (idx)
      3'd0: value = 8'd0;
      3'd1: value = 8'd2;
      3'd2: value = 8'd4;
      3'd3: value = 8'd5;
      3'd4: value = 8'd6;
      3'd5: value = 8'd7;
      default: value = 8'd0;
    endcase
    return value;
  endfunction

  function automatic logic [7:0] apply_limit(input logic [7:0] bank, input logic [7:0] limit);
    return (bank > limit) ? (bank & limit) : bank;
  endfunction

endpackage

>>> rtl/mmc3v_bank_ram.sv
// Eight-entry bank register memory with a registered read port.
// Entries not yet written read as their power-on values; uses mmc3v_pkg.
module mmc3v_bank_ram
  import mmc3v_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [BANK_REG_AW-1:0] wr_addr,
  input  logic [7:0]             wr_data,
  input  logic                   rd_en,
  input  logic [BANK_REG_AW-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0]           mem [CHR_SLOTS];
  logic [CHR_SLOTS-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : bank_reg_reset(rd_addr);
    end
  end

  // A read in the cycle after a write to the same entry returns the new value.
  assert property (@(posedge clk) disable iff (rst)
    wr_en ##1 (rd_en && !wr_en && rd_addr == $past(wr_addr)) |=>
      rd_data == $past(wr_data, 2))
    else $error("bank register read missed the preceding write");

endmodule

>>> rtl/mmc3v_front.sv
// Front stage: decodes accepted items, updates the outer and select registers,
// drives the bank memory ports and holds the item for translation; uses mmc3v_pkg.
module mmc3v_front
  import mmc3v_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   advance,
  input  mmc3v_in_t              req,
  input  logic                   ram_write_enable,
  output logic                   stage_valid,
  output mmc3v_stage_t           stage,
  output logic                   wr_en,
  output logic [BANK_REG_AW-1:0] wr_addr,
  output logic [7:0]             wr_data,
  output logic                   rd_en,
  output logic [BANK_REG_AW-1:0] rd_addr
);

  logic [7:0]   outer_register;
  logic [7:0]   bank_select;
  logic         is_write;
  logic         in_ram_window;
  logic         high_page;
  logic         select_hit;
  logic         data_hit;
  logic [7:0]   prg_base;
  logic [2:0]   slot;
  mmc3v_stage_t stage_next;

  assign is_write      = accept && (req.func == FUNC_CPU_WRITE);
  assign in_ram_window = (req.bus_address[15:13] == 3'b011);
  assign high_page     = req.bus_address[15];
  assign select_hit    = high_page && (req.bus_address[14:13] == 2'b00) && !req.bus_address[0];
  assign data_hit      = high_page && (req.bus_address[14:13] == 2'b00) && req.bus_address[0];

  always_comb begin
    prg_base = {3'b000, outer_register[3:0], 1'b0};
    if (req.bus_address[14]) begin
      prg_base[5] = prg_base[5] | outer_register[3];
    end
    slot = req.bus_address[12:10] ^ {bank_select[7], 2'b00};
  end

  assign wr_en   = is_write && data_hit;
  assign wr_addr = bank_select[BANK_REG_AW-1:0];
  assign wr_data = req.data_byte;
  assign rd_en   = accept;
  assign rd_addr = slot[2] ? (slot - 3'd2) : {2'b00, slot[1]};

  always_comb begin
    stage_next.func        = req.func;
    stage_next.forwarded   = (req.func == FUNC_CPU_WRITE) && high_page && !select_hit && !data_hit;
    stage_next.prg_bank    = {prg_base[7:1], req.bus_address[13]};
    stage_next.chr_slot    = slot;
    stage_next.low_address = req.bus_address[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_register <= '0;
      bank_select    <= '0;
    end else if (is_write) begin
      if (in_ram_window && ram_write_enable) begin
        outer_register <= req.data_byte;
      end
      if (select_hit) begin
        bank_select <= req.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  // A held item keeps its decoded contents until the back stage takes it.
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("front stage item changed while held");

endmodule

>>> rtl/mmc3v_back.sv
// Back stage: builds the PRG or CHR bank and ROM offset and holds the result
// item in the output register; uses mmc3v_pkg and the bank memory read data.
module mmc3v_back
  import mmc3v_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         stage_valid,
  input  mmc3v_stage_t stage,
  input  logic [7:0]   rd_data,
  input  logic [7:0]   prg_bank_limit,
  input  logic [7:0]   chr_bank_limit,
  output logic         rsp_valid,
  output mmc3v_out_t   rsp
);

  logic [7:0] chr_raw;
  logic [7:0] prg_bank;
  logic [7:0] chr_bank;
  mmc3v_out_t result;

  always_comb begin
    chr_raw  = stage.chr_slot[2] ? rd_data : {rd_data[7:1], stage.chr_slot[0]};
    prg_bank = apply_limit(stage.prg_bank, prg_bank_limit);
    chr_bank = apply_limit(chr_raw, chr_bank_limit);
    result   = '0;
    case (stage.func)
      FUNC_CPU_WRITE: begin
        result.forwarded = stage.forwarded;
      end
      FUNC_CPU_READ: begin
        result.bank_number = prg_bank;
        result.rom_offset  = {prg_bank, stage.low_address};
      end
      FUNC_PPU_READ: begin
        result.bank_number = chr_bank;
        result.rom_offset  = {3'b000, chr_bank, stage.low_address[9:0]};
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance && stage.func == FUNC_PPU_READ |=>
      rsp.bank_number <= chr_bank_limit && rsp.rom_offset[20:18] == 3'b000)
    else $error("CHR result exceeds its bank limit or offset range");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.forwarded |-> rsp.bank_number == 8'd0 && rsp.rom_offset == 21'd0)
    else $error("forwarded write carries a translation");

endmodule

>>> rtl/mmc3_variant_bank_mapper.sv
// An accepted input item is held in the decode stage register, then its result
// item in the output register; rsp_stall on a valid output can hold both.
// Throughput: one item per cycle while rsp_stall is low; the registered bank
// memory read sets the two-stage depth: decode stage, then output register.
// Reset (synchronous, active high) restores the valid and control registers and
// marks all bank entries unwritten, reading power-on values; no clearing pass.
module mmc3_variant_bank_mapper
  import mmc3v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  mmc3v_in_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output mmc3v_out_t rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic                   ram_write_enable;
  logic [7:0]             prg_bank_limit;
  logic [7:0]             chr_bank_limit;
  logic                   advance;
  logic                   accept;
  logic                   stage_valid;
  mmc3v_stage_t           stage;
  logic                   wr_en;
  logic [BANK_REG_AW-1:0] wr_addr;
  logic [7:0]             wr_data;
  logic                   rd_en;
  logic [BANK_REG_AW-1:0] rd_addr;
  logic [7:0]             rd_data;

  assign cfg_ready = 1'b1;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = stage_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_write_enable <= 1'b1;
      prg_bank_limit   <= 8'hFF;
      chr_bank_limit   <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RAM_WRITE_ENABLE: ram_write_enable <= cfg_data[0];
        CFG_PRG_BANK_LIMIT:   prg_bank_limit   <= cfg_data;
        CFG_CHR_BANK_LIMIT:   chr_bank_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mmc3v_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .advance          (advance),
    .req              (req),
    .ram_write_enable (ram_write_enable),
    .stage_valid      (stage_valid),
    .stage            (stage),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr)
  );

  mmc3v_bank_ram u_bank_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mmc3v_back u_back (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .stage_valid    (stage_valid),
    .stage          (stage),
    .rd_data        (rd_data),
    .prg_bank_limit (prg_bank_limit),
    .chr_bank_limit (chr_bank_limit),
    .rsp_valid      (rsp_valid),
    .rsp            (rsp)
  );

endmodule
